[hdl/dle_pkg.sv]
// ----------------------------------------------------------------------------
// DNS label encoder package
// Shared constants, types and the character folding function.
// ----------------------------------------------------------------------------
package dle_pkg;

   localparam int CHAR_W      = 8;
   localparam int MAX_LABEL   = 63;
   localparam int STORE_DEPTH = 63;
   localparam int LEN_W       = 6;

   localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2E;
   localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [LEN_W-1:0]  len_type;

   // Command from the input side to the drain sequencer when a label closes.
   typedef struct packed {
      logic    start;
      len_type count;
      logic    done;
      logic    overflow;
   } drain_cmd_type;

   // Fold A-Z to lower case; every other byte passes unchanged.
   function automatic char_type fold_lower(input char_type c);
      char_type r;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_DELTA;
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

[hdl/dle_chan_if.sv]
// ----------------------------------------------------------------------------
// DNS label encoder channels
// Valid/ready interfaces for the character input and the byte output.
// ----------------------------------------------------------------------------
interface dle_req_if;
   logic               valid;
   logic               ready;
   dle_pkg::char_type  char_in;
   logic               name_end;

   modport source (output valid, output char_in, output name_end, input ready);
   modport sink   (input valid, input char_in, input name_end, output ready);
endinterface

interface dle_rsp_if;
   logic               valid;
   logic               ready;
   dle_pkg::char_type  byte_out;
   logic               run_last;
   logic               name_done;
   logic               label_overflow;

   modport source (output valid, output byte_out, output run_last, output name_done,
                   output label_overflow, input ready);
   modport sink   (input valid, input byte_out, input run_last, input name_done,
                   input label_overflow, output ready);
endinterface

[hdl/dle_label_ram.sv]
// ----------------------------------------------------------------------------
// Label buffer RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dle_label_ram #(
   parameter int DEPTH = 63,
   parameter int WIDTH = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dle_drain.sv]
// ----------------------------------------------------------------------------
// Label drain sequencer
// Emits the length byte, then reads the buffered label out of the RAM.
// ----------------------------------------------------------------------------
module dle_drain (
   input  logic                   clock,
   input  logic                   reset,
   input  dle_pkg::drain_cmd_type cmd,
   output logic                   busy,
   output logic                   ram_rd_en,
   output dle_pkg::len_type       ram_rd_addr,
   input  dle_pkg::char_type      ram_rd_data,
   dle_rsp_if.source              rsp_if
);

   logic              busy_ff, busy_in;
   logic              hdr_ff, hdr_in;
   dle_pkg::len_type  len_ff, len_in;
   dle_pkg::len_type  left_ff, left_in;
   dle_pkg::len_type  rd_idx_ff, rd_idx_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;
   logic              lbl_done_ff, lbl_done_in;
   logic              lbl_ovf_ff, lbl_ovf_in;

   logic              out_valid_ff, out_valid_in;
   dle_pkg::char_type out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_done_ff, out_done_in;
   logic              out_ovf_ff, out_ovf_in;

   logic slot_free;
   logic hdr_load;
   logic pend_move;
   logic rd_issue;

   always_comb begin
      slot_free = !out_valid_ff || rsp_if.ready;
      hdr_load  = busy_ff && hdr_ff && slot_free;
      pend_move = !hdr_ff && pend_ff && slot_free;
      rd_issue  = busy_ff && (left_ff != '0) && (!pend_ff || pend_move);

      busy_in      = busy_ff;
      hdr_in       = hdr_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      lbl_done_in  = lbl_done_ff;
      lbl_ovf_in   = lbl_ovf_ff;

      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      out_ovf_in   = out_ovf_ff;

      if (hdr_load) begin
         hdr_in       = 1'b0;
         out_valid_in = 1'b1;
         out_byte_in  = dle_pkg::CHAR_W'(len_ff);
         out_last_in  = (len_ff == '0);
         out_done_in  = lbl_done_ff && (len_ff == '0);
         out_ovf_in   = lbl_ovf_ff;
         if (len_ff == '0) begin
            busy_in = 1'b0;
         end
      end else if (pend_move) begin
         out_valid_in = 1'b1;
         out_byte_in  = ram_rd_data;
         out_last_in  = pend_last_ff;
         out_done_in  = lbl_done_ff && pend_last_ff;
         out_ovf_in   = lbl_ovf_ff;
         if (pend_last_ff) begin
            busy_in = 1'b0;
         end
      end

      if (pend_move) begin
         pend_in = 1'b0;
      end
      if (rd_issue) begin
         pend_in      = 1'b1;
         pend_last_in = (left_ff == dle_pkg::LEN_W'(1));
         left_in      = left_ff - dle_pkg::LEN_W'(1);
         rd_idx_in    = rd_idx_ff + dle_pkg::LEN_W'(1);
      end

      // A new label is only handed over while the sequencer is idle.
      if (cmd.start) begin
         busy_in     = 1'b1;
         hdr_in      = 1'b1;
         len_in      = cmd.count;
         left_in     = cmd.count;
         rd_idx_in   = '0;
         pend_in     = 1'b0;
         lbl_done_in = cmd.done;
         lbl_ovf_in  = cmd.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         hdr_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         hdr_ff       <= hdr_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      rd_idx_ff    <= rd_idx_in;
      pend_last_ff <= pend_last_in;
      lbl_done_ff  <= lbl_done_in;
      lbl_ovf_ff   <= lbl_ovf_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign busy        = busy_ff;
   assign ram_rd_en   = rd_issue;
   assign ram_rd_addr = rd_idx_ff;

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.byte_out       = out_byte_ff;
   assign rsp_if.run_last       = out_last_ff;
   assign rsp_if.name_done      = out_done_ff;
   assign rsp_if.label_overflow = out_ovf_ff;

endmodule

[hdl/dns_label_encoder_top.sv]
// ----------------------------------------------------------------------------
// DNS label encoder
// Turns a dotted host name into length-prefixed, lower-cased DNS labels.
// ----------------------------------------------------------------------------
// Usage:
// The req_if channel takes one host name character per item, with name_end
// set on the final character. A dot closes the current label; the final
// character closes it too. The rsp_if channel returns, for each closed label,
// a length byte followed by the label's characters folded to lower case.
// run_last marks the last result byte caused by an input item, name_done the
// final byte of the whole name. Labels longer than 63 characters are cut to
// 63 and every byte of such a label carries label_overflow.
// Ordinary characters are taken one per cycle while no label drains. An item
// that closes a label sets the drain sequencer's busy and header flags; the
// length byte then enters the output register, followed by one character
// per cycle unless the receiver stalls. req_if.ready stays low while the
// sequencer walks the label RAM, whose single read port sets the drain rate.
// When the receiver stalls, the output register holds its item and the
// drain pauses; input resumes only after the last byte reaches that register.
// Synchronous reset empties the label and the output; the RAM needs no clear.
// ----------------------------------------------------------------------------
module dns_label_encoder_top (
   input  logic     clock,
   input  logic     reset,
   dle_req_if.sink  req_if,
   dle_rsp_if.source rsp_if
);

   dle_pkg::len_type       len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic                   drain_busy;
   dle_pkg::drain_cmd_type cmd;

   logic                   accept;
   logic                   is_dot;
   logic                   store;
   dle_pkg::len_type       new_len;
   logic                   new_ovf;
   logic                   ram_rd_en;
   dle_pkg::len_type       ram_rd_addr;
   dle_pkg::char_type      ram_rd_data;

   assign req_if.ready = !drain_busy;

   always_comb begin
      accept  = req_if.valid && req_if.ready;
      is_dot  = (req_if.char_in == dle_pkg::DOT_CHAR);
      // A character is kept only while the label has room; beyond that it
      // is dropped and the label is marked as truncated.
      store   = !is_dot && (len_ff < dle_pkg::LEN_W'(dle_pkg::MAX_LABEL));
      new_len = store ? len_ff + dle_pkg::LEN_W'(1) : len_ff;
      new_ovf = ovf_ff || (!is_dot && !store);

      cmd.start    = accept && (is_dot || req_if.name_end);
      cmd.count    = new_len;
      cmd.done     = req_if.name_end;
      cmd.overflow = new_ovf;

      len_in = len_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (cmd.start) begin
            len_in = '0;
            ovf_in = 1'b0;
         end else begin
            len_in = new_len;
            ovf_in = new_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   dle_label_ram #(
      .DEPTH  (dle_pkg::STORE_DEPTH),
      .WIDTH  (dle_pkg::CHAR_W),
      .ADDR_W (dle_pkg::LEN_W)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (accept && store),
      .wr_addr (len_ff),
      .wr_data (dle_pkg::fold_lower(req_if.char_in)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dle_drain u_drain (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .busy        (drain_busy),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_if      (rsp_if)
   );

endmodule
